[rtl/core/wstd_pkg.sv]
// Shared types and constants of the work-stealing task dispatcher.
package wstd_pkg;

	localparam int ID_W     = 16;
	localparam int HANDLE_W = 32;
	localparam int CNT_W    = 32;
	localparam int WC_W     = 3;
	localparam int CMP_W    = 5;

	typedef enum logic [1:0] {
		OP_SPAWN    = 2'd0,
		OP_DISPATCH = 2'd1,
		OP_CLEAR    = 2'd2,
		OP_NOP      = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		STAT_DONE       = 3'd0,
		STAT_POOL_FULL  = 3'd1,
		STAT_QUEUE_FULL = 3'd2,
		STAT_NOTHING    = 3'd3,
		STAT_BAD_WORKER = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_QDATA,
		ST_PDATA
	} state_t;

	typedef struct packed {
		logic wr;
		logic rd;
	} mem_ctl_t;

endpackage

[rtl/core/work_stealing_task_dispatcher_top.sv]
// Work-stealing task dispatcher top level: sequencer with queue ring memory and task pool memory.
// Spawn, clear, no-op and bad worker give done with the result registered in the execute state.
// Dispatch from the own queue passes the execute, queue data and pool data states; a steal first
// scans other queues (at most active workers less one); nothing to run ends the scan with no hit.
// busy stays high until the result is registered; a new request is taken in the done cycle.
// Reset clears pointers, pool count, statistics and worker count (to one); memories are not cleared.
module work_stealing_task_dispatcher_top import wstd_pkg::*; #(
	parameter int MAX_WORKERS = 4,
	parameter int QUEUE_DEPTH = 16,
	parameter int POOL_SLOTS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          opcode,
	input  logic [1:0]          worker,
	input  logic [HANDLE_W-1:0] task_handle,
	input  logic                cfg_we,
	input  logic [WC_W-1:0]     cfg_data,
	output logic                done,
	output logic [2:0]          status,
	output logic [5:0]          task_slot,
	output logic [ID_W-1:0]     task_id,
	output logic [HANDLE_W-1:0] task_handle_out,
	output logic                was_stolen,
	output logic [6:0]          pending_count,
	output logic [CNT_W-1:0]    enqueued_total,
	output logic [CNT_W-1:0]    executed_total,
	output logic [CNT_W-1:0]    stolen_total,
	output logic [CNT_W-1:0]    failed_spawn_total
);

	localparam int SW  = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
	localparam int QAW = $clog2(MAX_WORKERS * QUEUE_DEPTH);
	localparam int PDW = ID_W + HANDLE_W;

	mem_ctl_t        q_ctl, p_ctl;
	logic [QAW-1:0]  q_waddr, q_raddr;
	logic [SW-1:0]   q_wdata, q_rdata;
	logic [SW-1:0]   p_waddr, p_raddr;
	logic [PDW-1:0]  p_wdata, p_rdata;

	wstd_ram #(
		.DEPTH (MAX_WORKERS * QUEUE_DEPTH),
		.DW    (SW)
	) u_queue_ram (
		.clk   (clk),
		.ctl   (q_ctl),
		.waddr (q_waddr),
		.wdata (q_wdata),
		.raddr (q_raddr),
		.rdata (q_rdata)
	);

	wstd_ram #(
		.DEPTH (POOL_SLOTS),
		.DW    (PDW)
	) u_pool_ram (
		.clk   (clk),
		.ctl   (p_ctl),
		.waddr (p_waddr),
		.wdata (p_wdata),
		.raddr (p_raddr),
		.rdata (p_rdata)
	);

	wstd_ctrl #(
		.MAX_WORKERS (MAX_WORKERS),
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.POOL_SLOTS  (POOL_SLOTS)
	) u_ctrl (
		.clk                (clk),
		.arst_n             (arst_n),
		.start              (start),
		.busy               (busy),
		.opcode             (opcode),
		.worker             (worker),
		.task_handle        (task_handle),
		.cfg_we             (cfg_we),
		.cfg_data           (cfg_data),
		.done               (done),
		.status             (status),
		.task_slot          (task_slot),
		.task_id            (task_id),
		.task_handle_out    (task_handle_out),
		.was_stolen         (was_stolen),
		.pending_count      (pending_count),
		.enqueued_total     (enqueued_total),
		.executed_total     (executed_total),
		.stolen_total       (stolen_total),
		.failed_spawn_total (failed_spawn_total),
		.q_ctl              (q_ctl),
		.q_waddr            (q_waddr),
		.q_wdata            (q_wdata),
		.q_raddr            (q_raddr),
		.q_rdata            (q_rdata),
		.p_ctl              (p_ctl),
		.p_waddr            (p_waddr),
		.p_wdata            (p_wdata),
		.p_raddr            (p_raddr),
		.p_rdata            (p_rdata)
	);

endmodule

[rtl/core/wstd_ram.sv]
// Single-port-write, single-port-read synchronous memory; read data is registered.
module wstd_ram import wstd_pkg::*; #(
	parameter int DEPTH = 64,
	parameter int DW = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  mem_ctl_t      ctl,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			mem_q[waddr] <= wdata;
		end
		if (ctl.rd) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/core/wstd_ctrl.sv]
// Request sequencer: queue pointers, pool allocation, steal scan, statistics and result.
module wstd_ctrl import wstd_pkg::*; #(
	parameter int MAX_WORKERS = 4,
	parameter int QUEUE_DEPTH = 16,
	parameter int POOL_SLOTS = 64,
	localparam int SW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1,
	localparam int QAW = $clog2(MAX_WORKERS * QUEUE_DEPTH)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [1:0]             opcode,
	input  logic [1:0]             worker,
	input  logic [HANDLE_W-1:0]    task_handle,
	input  logic                   cfg_we,
	input  logic [WC_W-1:0]        cfg_data,
	output logic                   done,
	output logic [2:0]             status,
	output logic [5:0]             task_slot,
	output logic [ID_W-1:0]        task_id,
	output logic [HANDLE_W-1:0]    task_handle_out,
	output logic                   was_stolen,
	output logic [6:0]             pending_count,
	output logic [CNT_W-1:0]       enqueued_total,
	output logic [CNT_W-1:0]       executed_total,
	output logic [CNT_W-1:0]       stolen_total,
	output logic [CNT_W-1:0]       failed_spawn_total,
	output mem_ctl_t               q_ctl,
	output logic [QAW-1:0]         q_waddr,
	output logic [SW-1:0]          q_wdata,
	output logic [QAW-1:0]         q_raddr,
	input  logic [SW-1:0]          q_rdata,
	output mem_ctl_t               p_ctl,
	output logic [SW-1:0]          p_waddr,
	output logic [ID_W+HANDLE_W-1:0] p_wdata,
	output logic [SW-1:0]          p_raddr,
	input  logic [ID_W+HANDLE_W-1:0] p_rdata
);

	localparam int WW  = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
	localparam int NW  = $clog2(MAX_WORKERS + 1);
	localparam int QW  = $clog2(QUEUE_DEPTH);
	localparam int FW  = $clog2(QUEUE_DEPTH + 1);
	localparam int UW  = $clog2(POOL_SLOTS + 1);
	localparam int PSW = $clog2(MAX_WORKERS * QUEUE_DEPTH + 1);

	function automatic logic [WW-1:0] wnext(input logic [WW-1:0] w, input logic [CMP_W-1:0] n);
		logic [CMP_W-1:0] s;
		s = CMP_W'(w) + CMP_W'(1);
		return (s == n) ? '0 : s[WW-1:0];
	endfunction

	function automatic logic [QW-1:0] pinc(input logic [QW-1:0] p);
		return (p == QW'(QUEUE_DEPTH - 1)) ? '0 : p + QW'(1);
	endfunction

	function automatic logic [QW-1:0] pdec(input logic [QW-1:0] p);
		return (p == '0) ? QW'(QUEUE_DEPTH - 1) : p - QW'(1);
	endfunction

	function automatic logic [QAW-1:0] qaddr(input logic [WW-1:0] w, input logic [QW-1:0] p);
		logic [31:0] a;
		a = 32'(w) * 32'(QUEUE_DEPTH) + 32'(p);
		return a[QAW-1:0];
	endfunction

	state_t              state_q, state_d;
	logic [WC_W-1:0]     wc_q;
	opcode_t             op_q, op_d;
	logic [1:0]          wrk_q, wrk_d;
	logic [HANDLE_W-1:0] hdl_q, hdl_d;
	logic [QW-1:0]       head_q [MAX_WORKERS];
	logic [QW-1:0]       head_d [MAX_WORKERS];
	logic [QW-1:0]       tail_q [MAX_WORKERS];
	logic [QW-1:0]       tail_d [MAX_WORKERS];
	logic [FW-1:0]       fill_q [MAX_WORKERS];
	logic [FW-1:0]       fill_d [MAX_WORKERS];
	logic [UW-1:0]       used_q, used_d;
	logic [ID_W-1:0]     nid_q, nid_d;
	logic [WW-1:0]       rr_q, rr_d;
	logic [WW-1:0]       scan_w_q, scan_w_d;
	logic [NW-1:0]       scan_cnt_q, scan_cnt_d;
	logic                stl_q, stl_d;
	logic [SW-1:0]       slot_q, slot_d;
	logic [CNT_W-1:0]    enq_cnt_q, enq_cnt_d;
	logic [CNT_W-1:0]    exe_cnt_q, exe_cnt_d;
	logic [CNT_W-1:0]    stolen_cnt_q, stolen_cnt_d;
	logic [CNT_W-1:0]    fail_cnt_q, fail_cnt_d;
	logic                res_vld_q, res_vld_d;
	status_t             res_status_q, res_status_d;
	logic [SW-1:0]       res_slot_q, res_slot_d;
	logic [ID_W-1:0]     res_id_q, res_id_d;
	logic [HANDLE_W-1:0] res_hdl_q, res_hdl_d;
	logic                res_stl_q, res_stl_d;

	logic [CMP_W-1:0] wc_ext, n_ext, wrk_ext;
	logic [WW-1:0]    widx, target;
	logic [SW-1:0]    new_slot;
	logic [QW-1:0]    steal_ptr;
	logic             bad_wrk, own_has, pool_full, q_full, scan_end, scan_hit;
	logic [PSW-1:0]   psum;

	assign wc_ext  = CMP_W'(wc_q);
	assign n_ext   = (wc_q == '0) ? CMP_W'(1) :
	                 ((wc_ext > CMP_W'(MAX_WORKERS)) ? CMP_W'(MAX_WORKERS) : wc_ext);
	assign wrk_ext = CMP_W'(wrk_q);
	assign widx    = wrk_ext[WW-1:0];
	assign target  = (CMP_W'(rr_q) < n_ext) ? rr_q : '0;
	assign new_slot = used_q[SW-1:0];
	assign steal_ptr = pdec(tail_q[scan_w_q]);

	assign bad_wrk   = wrk_ext >= n_ext;
	assign own_has   = fill_q[widx] != '0;
	assign pool_full = used_q >= UW'(POOL_SLOTS);
	assign q_full    = fill_q[target] >= FW'(QUEUE_DEPTH);
	assign scan_end  = CMP_W'(scan_cnt_q) >= n_ext;
	assign scan_hit  = fill_q[scan_w_q] != '0;

	always_comb begin
		psum = '0;
		for (int i = 0; i < MAX_WORKERS; i++) begin
			if (CMP_W'(i) < n_ext) begin
				psum = psum + PSW'(fill_q[i]);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (op_q == OP_DISPATCH && !bad_wrk) begin
					state_d = own_has ? ST_QDATA : ST_SCAN;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_SCAN: begin
				priority if (scan_end) begin
					state_d = ST_IDLE;
				end else if (scan_hit) begin
					state_d = ST_QDATA;
				end else begin
					state_d = ST_SCAN;
				end
			end
			ST_QDATA: state_d = ST_PDATA;
			ST_PDATA: state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		op_d         = op_q;
		wrk_d        = wrk_q;
		hdl_d        = hdl_q;
		head_d       = head_q;
		tail_d       = tail_q;
		fill_d       = fill_q;
		used_d       = used_q;
		nid_d        = nid_q;
		rr_d         = rr_q;
		scan_w_d     = scan_w_q;
		scan_cnt_d   = scan_cnt_q;
		stl_d        = stl_q;
		slot_d       = slot_q;
		enq_cnt_d    = enq_cnt_q;
		exe_cnt_d    = exe_cnt_q;
		stolen_cnt_d = stolen_cnt_q;
		fail_cnt_d   = fail_cnt_q;
		res_vld_d    = 1'b0;
		res_status_d = res_status_q;
		res_slot_d   = res_slot_q;
		res_id_d     = res_id_q;
		res_hdl_d    = res_hdl_q;
		res_stl_d    = res_stl_q;
		q_ctl        = '0;
		q_waddr      = '0;
		q_wdata      = new_slot;
		q_raddr      = '0;
		p_ctl        = '0;
		p_waddr      = new_slot;
		p_wdata      = {nid_q, hdl_q};
		p_raddr      = q_rdata;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					op_d  = opcode_t'(opcode);
					wrk_d = worker;
					hdl_d = task_handle;
				end
			end
			ST_EXEC: begin
				res_status_d = STAT_DONE;
				res_slot_d   = '0;
				res_id_d     = '0;
				res_hdl_d    = '0;
				res_stl_d    = 1'b0;
				unique case (op_q)
					OP_SPAWN: begin
						res_vld_d = 1'b1;
						if (pool_full) begin
							res_status_d = STAT_POOL_FULL;
							fail_cnt_d   = fail_cnt_q + CNT_W'(1);
						end else begin
							p_ctl.wr   = 1'b1;
							used_d     = used_q + UW'(1);
							nid_d      = nid_q + ID_W'(1);
							rr_d       = wnext(target, n_ext);
							res_slot_d = new_slot;
							res_id_d   = nid_q;
							if (q_full) begin
								res_status_d = STAT_QUEUE_FULL;
								fail_cnt_d   = fail_cnt_q + CNT_W'(1);
							end else begin
								q_ctl.wr       = 1'b1;
								q_waddr        = qaddr(target, tail_q[target]);
								tail_d[target] = pinc(tail_q[target]);
								fill_d[target] = fill_q[target] + FW'(1);
								enq_cnt_d      = enq_cnt_q + CNT_W'(1);
							end
						end
					end
					OP_DISPATCH: begin
						priority if (bad_wrk) begin
							res_vld_d    = 1'b1;
							res_status_d = STAT_BAD_WORKER;
						end else if (own_has) begin
							q_ctl.rd     = 1'b1;
							q_raddr      = qaddr(widx, head_q[widx]);
							head_d[widx] = pinc(head_q[widx]);
							fill_d[widx] = fill_q[widx] - FW'(1);
							stl_d        = 1'b0;
						end else begin
							scan_w_d   = wnext(widx, n_ext);
							scan_cnt_d = NW'(1);
						end
					end
					OP_CLEAR: begin
						res_vld_d = 1'b1;
						for (int i = 0; i < MAX_WORKERS; i++) begin
							head_d[i] = '0;
							tail_d[i] = '0;
							fill_d[i] = '0;
						end
						used_d = '0;
						rr_d   = '0;
					end
					OP_NOP: begin
						res_vld_d = 1'b1;
					end
				endcase
			end
			ST_SCAN: begin
				priority if (scan_end) begin
					res_vld_d    = 1'b1;
					res_status_d = STAT_NOTHING;
				end else if (scan_hit) begin
					q_ctl.rd         = 1'b1;
					q_raddr          = qaddr(scan_w_q, steal_ptr);
					tail_d[scan_w_q] = steal_ptr;
					fill_d[scan_w_q] = fill_q[scan_w_q] - FW'(1);
					stl_d            = 1'b1;
				end else begin
					scan_w_d   = wnext(scan_w_q, n_ext);
					scan_cnt_d = scan_cnt_q + NW'(1);
				end
			end
			ST_QDATA: begin
				p_ctl.rd = 1'b1;
				slot_d   = q_rdata;
			end
			ST_PDATA: begin
				res_vld_d    = 1'b1;
				res_status_d = STAT_DONE;
				res_slot_d   = slot_q;
				res_id_d     = p_rdata[ID_W+HANDLE_W-1:HANDLE_W];
				res_hdl_d    = p_rdata[HANDLE_W-1:0];
				res_stl_d    = stl_q;
				exe_cnt_d    = exe_cnt_q + CNT_W'(1);
				if (stl_q) begin
					stolen_cnt_d = stolen_cnt_q + CNT_W'(1);
				end
			end
			default: begin
				res_vld_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			wc_q         <= WC_W'(1);
			for (int i = 0; i < MAX_WORKERS; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				fill_q[i] <= '0;
			end
			used_q       <= '0;
			nid_q        <= ID_W'(1);
			rr_q         <= '0;
			scan_cnt_q   <= '0;
			enq_cnt_q    <= '0;
			exe_cnt_q    <= '0;
			stolen_cnt_q <= '0;
			fail_cnt_q   <= '0;
			res_vld_q    <= 1'b0;
		end else begin
			state_q      <= state_d;
			if (cfg_we) begin
				wc_q <= cfg_data;
			end
			head_q       <= head_d;
			tail_q       <= tail_d;
			fill_q       <= fill_d;
			used_q       <= used_d;
			nid_q        <= nid_d;
			rr_q         <= rr_d;
			scan_cnt_q   <= scan_cnt_d;
			enq_cnt_q    <= enq_cnt_d;
			exe_cnt_q    <= exe_cnt_d;
			stolen_cnt_q <= stolen_cnt_d;
			fail_cnt_q   <= fail_cnt_d;
			res_vld_q    <= res_vld_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q         <= op_d;
		wrk_q        <= wrk_d;
		hdl_q        <= hdl_d;
		scan_w_q     <= scan_w_d;
		stl_q        <= stl_d;
		slot_q       <= slot_d;
		res_status_q <= res_status_d;
		res_slot_q   <= res_slot_d;
		res_id_q     <= res_id_d;
		res_hdl_q    <= res_hdl_d;
		res_stl_q    <= res_stl_d;
	end

	assign busy               = state_q != ST_IDLE;
	assign done               = res_vld_q;
	assign status             = res_status_q;
	assign task_slot          = 6'(res_slot_q);
	assign task_id            = res_id_q;
	assign task_handle_out    = res_hdl_q;
	assign was_stolen         = res_stl_q;
	assign pending_count      = 7'(psum);
	assign enqueued_total     = enq_cnt_q;
	assign executed_total     = exe_cnt_q;
	assign stolen_total       = stolen_cnt_q;
	assign failed_spawn_total = fail_cnt_q;

`ifndef SYNTHESIS
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> state_q == ST_EXEC)
		else $error("accepted request did not enter execution");
	a_qdata_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_QDATA |-> $past(q_ctl.rd))
		else $error("queue data taken without a queue read");
	a_pdata_after_qdata: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PDATA |-> $past(state_q) == ST_QDATA)
		else $error("pool data stage not preceded by queue data stage");
	a_qwr_with_pwr: assert property (@(posedge clk) disable iff (!arst_n)
		q_ctl.wr |-> p_ctl.wr && state_q == ST_EXEC)
		else $error("queue write without pool allocation");
	a_steal_counts_exec: assert property (@(posedge clk) disable iff (!arst_n)
		stolen_cnt_q != $past(stolen_cnt_q) |-> exe_cnt_q != $past(exe_cnt_q))
		else $error("steal counted without a dispatch");
`endif

endmodule
